// ----- hw/rtl/lft_pkg.sv -----
// Package for the logic formula tokenizer: token kind codes, scanner mode codes,
// character constants and the character class functions.
// Depends on nothing; used by logic_formula_tokenizer_unit.
package lft_pkg;

	localparam int KIND_BITS = 5;
	localparam int MODE_BITS = 4;

	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [MODE_BITS-1:0] mode_t;

	localparam kind_t TK_EOF        = 5'd0;
	localparam kind_t TK_IDENT      = 5'd1;
	localparam kind_t TK_STRING     = 5'd2;
	localparam kind_t TK_LPAREN     = 5'd3;
	localparam kind_t TK_RPAREN     = 5'd4;
	localparam kind_t TK_LBRACK     = 5'd5;
	localparam kind_t TK_RBRACK     = 5'd6;
	localparam kind_t TK_COMMA      = 5'd7;
	localparam kind_t TK_DOT        = 5'd8;
	localparam kind_t TK_COLON      = 5'd9;
	localparam kind_t TK_AND        = 5'd10;
	localparam kind_t TK_OR         = 5'd11;
	localparam kind_t TK_NOT        = 5'd12;
	localparam kind_t TK_BANG       = 5'd13;
	localparam kind_t TK_QUEST      = 5'd14;
	localparam kind_t TK_EQ         = 5'd15;
	localparam kind_t TK_NEQ        = 5'd16;
	localparam kind_t TK_IFF        = 5'd17;
	localparam kind_t TK_IMPL       = 5'd18;
	localparam kind_t TK_RIMPL      = 5'd19;
	localparam kind_t TK_XOR        = 5'd20;
	localparam kind_t TK_NOR        = 5'd21;
	localparam kind_t TK_NAND       = 5'd22;
	localparam kind_t TK_GT         = 5'd23;
	localparam kind_t TK_STAR       = 5'd24;
	localparam kind_t TK_AT         = 5'd25;
	localparam kind_t TK_BAD_CHAR   = 5'd26;
	localparam kind_t TK_UNTERM_STR = 5'd27;

	localparam mode_t M_GROUND     = 4'd0;
	localparam mode_t M_ID         = 4'd1;
	localparam mode_t M_STR        = 4'd2;
	localparam mode_t M_STR_ESC    = 4'd3;
	localparam mode_t M_LINE       = 4'd4;
	localparam mode_t M_BLOCK      = 4'd5;
	localparam mode_t M_BLOCK_STAR = 4'd6;
	localparam mode_t M_SLASH      = 4'd7;
	localparam mode_t M_LT         = 4'd8;
	localparam mode_t M_LT_EQ      = 4'd9;
	localparam mode_t M_LT_TILDE   = 4'd10;
	localparam mode_t M_TILDE      = 4'd11;
	localparam mode_t M_BANG       = 4'd12;
	localparam mode_t M_EQ         = 4'd13;
	localparam mode_t M_ERROR      = 4'd14;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_TILDE   = 8'h7E;

	function automatic logic is_alnum(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic id_first(input logic [7:0] b);
		return is_alnum(b) || b == CH_DOLLAR || b == CH_USCORE;
	endfunction

	function automatic logic id_more(input logic [7:0] b);
		return id_first(b) || b == CH_SQUOTE || b == CH_MINUS;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	// Returns TK_EOF for a byte that is not a single-character token.
	function automatic kind_t single_kind(input logic [7:0] b);
		kind_t k;
		case (b)
			8'h28: k = TK_LPAREN;
			8'h29: k = TK_RPAREN;
			8'h5B: k = TK_LBRACK;
			8'h5D: k = TK_RBRACK;
			8'h2C: k = TK_COMMA;
			8'h2E: k = TK_DOT;
			8'h3A: k = TK_COLON;
			CH_AMP: k = TK_AND;
			CH_BAR: k = TK_OR;
			8'h3F: k = TK_QUEST;
			CH_GT: k = TK_GT;
			CH_STAR: k = TK_STAR;
			8'h40: k = TK_AT;
			default: k = TK_EOF;
		endcase
		return k;
	endfunction

endpackage

// ----- hw/rtl/logic_formula_tokenizer_unit.sv -----
// Logic formula tokenizer: input register, one-pass scanner logic and a two-entry
// result buffer on the output stream.
// Depends on lft_pkg.
//
// The block takes one text byte per cycle on the slave stream while the result
// buffer has room (tuser marks the end of the text) and produces tokens on the
// master stream, one result per transfer. Each byte is held in the input register
// until the scanner can place all of its results in the two-entry result buffer,
// which drives the master stream; the buffer sets the pace, and a stalled output
// holds the input back. Identifier and string text streams one byte per result,
// flagged last on its final byte; all other tokens are single results.
// Start line and column saturate at 2^POSITION_BITS - 1.
module logic_formula_tokenizer_unit #(
	parameter int POSITION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata, // [7:0] input_byte
	input  logic s_axis_tuser,       // [0] end_of_input
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [7:0] text_byte, then start_line, then start_column, zero-filled to bytes
	output logic [((8 + 2*POSITION_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	output logic m_axis_tlast,       // last_of_token
	output logic [5:0] m_axis_tuser  // [4:0] kind of token, [5] has_text
);

	localparam int P = POSITION_BITS;
	localparam int TW = ((8 + 2*P + 7) / 8) * 8;
	localparam logic [P-1:0] POS_MAX = '1;
	localparam logic [P-1:0] POS_ONE = {{(P-1){1'b0}}, 1'b1};

	typedef struct packed {
		lft_pkg::kind_t kind;
		logic [7:0] text;
		logic has;
		logic last;
		logic [P-1:0] line;
		logic [P-1:0] col;
	} res_t;

	function automatic res_t mk(input lft_pkg::kind_t kind, input logic [7:0] text,
		input logic has, input logic last, input logic [P-1:0] line,
		input logic [P-1:0] col);
		res_t r;
		r.kind = kind;
		r.text = text;
		r.has = has;
		r.last = last;
		r.line = line;
		r.col = col;
		return r;
	endfunction

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eoi_s1;

	lft_pkg::mode_t mode_q, mode_n;
	logic [7:0] held_q, held_n;
	logic hv_q, hv_n;
	logic dq_q, dq_n;
	logic [P-1:0] tok_line_q, tok_line_n, tok_col_q, tok_col_n;
	logic [P-1:0] cur_line_q, cur_line_n, cur_col_q, cur_col_n;

	res_t res [2];
	logic [1:0] n_res;

	res_t buf_q [2];
	res_t buf_n [2];
	logic [1:0] cnt_q, cnt_n, cnt_ap;
	logic pop, fire;

	assign pop = m_axis_tvalid && m_axis_tready;
	assign cnt_ap = cnt_q - {1'b0, pop};
	assign fire = valid_s1 && (({1'b0, cnt_ap} + {1'b0, n_res}) <= 3'd2);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eoi_s1 <= s_axis_tuser;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic [P-1:0] pl, pc;
		logic do_ground;
		lft_pkg::kind_t sk;
		b = byte_s1;
		pl = cur_line_q;
		pc = cur_col_q;
		do_ground = 1'b0;
		sk = lft_pkg::single_kind(b);
		mode_n = mode_q;
		held_n = held_q;
		hv_n = hv_q;
		dq_n = dq_q;
		tok_line_n = tok_line_q;
		tok_col_n = tok_col_q;
		cur_line_n = cur_line_q;
		cur_col_n = cur_col_q;
		res[0] = '0;
		res[1] = '0;
		n_res = 2'd0;
		if (eoi_s1) begin
			case (mode_q)
				lft_pkg::M_ID: begin
					if (hv_q) begin
						res[n_res[0]] = mk(lft_pkg::TK_IDENT, held_q, 1'b1, 1'b1,
							tok_line_q, tok_col_q);
						n_res = n_res + 2'd1;
					end
				end
				lft_pkg::M_STR, lft_pkg::M_STR_ESC: begin
					res[n_res[0]] = mk(lft_pkg::TK_UNTERM_STR, 8'd0, 1'b0, 1'b1,
						tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
				end
				lft_pkg::M_SLASH, lft_pkg::M_LT, lft_pkg::M_LT_TILDE: begin
					res[n_res[0]] = mk(lft_pkg::TK_BAD_CHAR, 8'd0, 1'b0, 1'b1,
						tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
				end
				lft_pkg::M_LT_EQ: begin
					res[n_res[0]] = mk(lft_pkg::TK_RIMPL, 8'd0, 1'b0, 1'b1,
						tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
				end
				lft_pkg::M_TILDE: begin
					res[n_res[0]] = mk(lft_pkg::TK_NOT, 8'd0, 1'b0, 1'b1,
						tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
				end
				lft_pkg::M_BANG: begin
					res[n_res[0]] = mk(lft_pkg::TK_BANG, 8'd0, 1'b0, 1'b1,
						tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
				end
				lft_pkg::M_EQ: begin
					res[n_res[0]] = mk(lft_pkg::TK_EQ, 8'd0, 1'b0, 1'b1,
						tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
				end
				default: begin
				end
			endcase
			res[n_res[0]] = mk(lft_pkg::TK_EOF, 8'd0, 1'b0, 1'b1, cur_line_q, cur_col_q);
			n_res = n_res + 2'd1;
			mode_n = lft_pkg::M_GROUND;
			held_n = 8'd0;
			hv_n = 1'b0;
			dq_n = 1'b0;
			tok_line_n = POS_ONE;
			tok_col_n = POS_ONE;
			cur_line_n = POS_ONE;
			cur_col_n = POS_ONE;
		end else if (mode_q != lft_pkg::M_ERROR) begin
			if (b == lft_pkg::CH_NL) begin
				if (cur_line_q != POS_MAX) begin
					cur_line_n = cur_line_q + POS_ONE;
				end
				cur_col_n = POS_ONE;
			end else if (cur_col_q != POS_MAX) begin
				cur_col_n = cur_col_q + POS_ONE;
			end
			case (mode_q)
				lft_pkg::M_ID: begin
					if (hv_q) begin
						res[n_res[0]] = mk(lft_pkg::TK_IDENT, held_q, 1'b1,
							!lft_pkg::id_more(b), tok_line_q, tok_col_q);
						n_res = n_res + 2'd1;
						hv_n = 1'b0;
					end
					if (lft_pkg::id_more(b)) begin
						held_n = b;
						hv_n = 1'b1;
					end else begin
						do_ground = 1'b1;
					end
				end
				lft_pkg::M_STR: begin
					if (b == (dq_q ? lft_pkg::CH_DQUOTE : lft_pkg::CH_SQUOTE)) begin
						res[n_res[0]] = mk(lft_pkg::TK_STRING, hv_q ? held_q : 8'd0, hv_q,
							1'b1, tok_line_q, tok_col_q);
						n_res = n_res + 2'd1;
						hv_n = 1'b0;
						mode_n = lft_pkg::M_GROUND;
					end else begin
						if (hv_q) begin
							res[n_res[0]] = mk(lft_pkg::TK_STRING, held_q, 1'b1, 1'b0,
								tok_line_q, tok_col_q);
							n_res = n_res + 2'd1;
						end
						held_n = b;
						hv_n = 1'b1;
						if (b == lft_pkg::CH_BSLASH) begin
							mode_n = lft_pkg::M_STR_ESC;
						end
					end
				end
				lft_pkg::M_STR_ESC: begin
					if (hv_q) begin
						res[n_res[0]] = mk(lft_pkg::TK_STRING, held_q, 1'b1, 1'b0,
							tok_line_q, tok_col_q);
						n_res = n_res + 2'd1;
					end
					held_n = b;
					hv_n = 1'b1;
					mode_n = lft_pkg::M_STR;
				end
				lft_pkg::M_LINE: begin
					if (b == lft_pkg::CH_NL) begin
						mode_n = lft_pkg::M_GROUND;
					end
				end
				lft_pkg::M_BLOCK: begin
					if (b == lft_pkg::CH_STAR) begin
						mode_n = lft_pkg::M_BLOCK_STAR;
					end
				end
				lft_pkg::M_BLOCK_STAR: begin
					if (b == lft_pkg::CH_SLASH) begin
						mode_n = lft_pkg::M_GROUND;
					end else if (b != lft_pkg::CH_STAR) begin
						mode_n = lft_pkg::M_BLOCK;
					end
				end
				lft_pkg::M_SLASH: begin
					if (b == lft_pkg::CH_STAR) begin
						mode_n = lft_pkg::M_BLOCK;
					end else begin
						mode_n = lft_pkg::M_ERROR;
						res[n_res[0]] = mk(lft_pkg::TK_BAD_CHAR, 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q);
						n_res = n_res + 2'd1;
					end
				end
				lft_pkg::M_LT: begin
					if (b == lft_pkg::CH_EQ) begin
						mode_n = lft_pkg::M_LT_EQ;
					end else if (b == lft_pkg::CH_TILDE) begin
						mode_n = lft_pkg::M_LT_TILDE;
					end else begin
						mode_n = lft_pkg::M_ERROR;
						res[n_res[0]] = mk(lft_pkg::TK_BAD_CHAR, 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q);
						n_res = n_res + 2'd1;
					end
				end
				lft_pkg::M_LT_EQ: begin
					res[n_res[0]] = mk((b == lft_pkg::CH_GT) ? lft_pkg::TK_IFF :
						lft_pkg::TK_RIMPL, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
					mode_n = lft_pkg::M_GROUND;
					do_ground = (b != lft_pkg::CH_GT);
				end
				lft_pkg::M_LT_TILDE: begin
					if (b == lft_pkg::CH_GT) begin
						mode_n = lft_pkg::M_GROUND;
						res[n_res[0]] = mk(lft_pkg::TK_XOR, 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q);
					end else begin
						mode_n = lft_pkg::M_ERROR;
						res[n_res[0]] = mk(lft_pkg::TK_BAD_CHAR, 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q);
					end
					n_res = n_res + 2'd1;
				end
				lft_pkg::M_TILDE: begin
					mode_n = lft_pkg::M_GROUND;
					if (b == lft_pkg::CH_BAR) begin
						res[n_res[0]] = mk(lft_pkg::TK_NOR, 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q);
					end else if (b == lft_pkg::CH_AMP) begin
						res[n_res[0]] = mk(lft_pkg::TK_NAND, 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q);
					end else begin
						res[n_res[0]] = mk(lft_pkg::TK_NOT, 8'd0, 1'b0, 1'b1,
							tok_line_q, tok_col_q);
						do_ground = 1'b1;
					end
					n_res = n_res + 2'd1;
				end
				lft_pkg::M_BANG: begin
					res[n_res[0]] = mk((b == lft_pkg::CH_EQ) ? lft_pkg::TK_NEQ :
						lft_pkg::TK_BANG, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
					mode_n = lft_pkg::M_GROUND;
					do_ground = (b != lft_pkg::CH_EQ);
				end
				lft_pkg::M_EQ: begin
					res[n_res[0]] = mk((b == lft_pkg::CH_GT) ? lft_pkg::TK_IMPL :
						lft_pkg::TK_EQ, 8'd0, 1'b0, 1'b1, tok_line_q, tok_col_q);
					n_res = n_res + 2'd1;
					mode_n = lft_pkg::M_GROUND;
					do_ground = (b != lft_pkg::CH_GT);
				end
				default: begin
					do_ground = 1'b1;
				end
			endcase
			if (do_ground) begin
				mode_n = lft_pkg::M_GROUND;
				if (lft_pkg::is_space(b)) begin
					mode_n = lft_pkg::M_GROUND;
				end else if (b == lft_pkg::CH_PERCENT) begin
					mode_n = lft_pkg::M_LINE;
				end else begin
					tok_line_n = pl;
					tok_col_n = pc;
					if (b == lft_pkg::CH_SLASH) begin
						mode_n = lft_pkg::M_SLASH;
					end else if (b == lft_pkg::CH_LT) begin
						mode_n = lft_pkg::M_LT;
					end else if (b == lft_pkg::CH_TILDE) begin
						mode_n = lft_pkg::M_TILDE;
					end else if (b == lft_pkg::CH_BANG) begin
						mode_n = lft_pkg::M_BANG;
					end else if (b == lft_pkg::CH_EQ) begin
						mode_n = lft_pkg::M_EQ;
					end else if (b == lft_pkg::CH_SQUOTE || b == lft_pkg::CH_DQUOTE) begin
						mode_n = lft_pkg::M_STR;
						dq_n = (b == lft_pkg::CH_DQUOTE);
						hv_n = 1'b0;
					end else if (sk != lft_pkg::TK_EOF) begin
						res[n_res[0]] = mk(sk, 8'd0, 1'b0, 1'b1, pl, pc);
						n_res = n_res + 2'd1;
					end else if (lft_pkg::id_first(b)) begin
						mode_n = lft_pkg::M_ID;
						held_n = b;
						hv_n = 1'b1;
					end else begin
						mode_n = lft_pkg::M_ERROR;
						res[n_res[0]] = mk(lft_pkg::TK_BAD_CHAR, 8'd0, 1'b0, 1'b1, pl, pc);
						n_res = n_res + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lft_pkg::M_GROUND;
			held_q <= 8'd0;
			hv_q <= 1'b0;
			dq_q <= 1'b0;
			tok_line_q <= POS_ONE;
			tok_col_q <= POS_ONE;
			cur_line_q <= POS_ONE;
			cur_col_q <= POS_ONE;
		end else if (fire) begin
			mode_q <= mode_n;
			held_q <= held_n;
			hv_q <= hv_n;
			dq_q <= dq_n;
			tok_line_q <= tok_line_n;
			tok_col_q <= tok_col_n;
			cur_line_q <= cur_line_n;
			cur_col_q <= cur_col_n;
		end
	end

	always_comb begin
		buf_n[0] = pop ? buf_q[1] : buf_q[0];
		buf_n[1] = buf_q[1];
		cnt_n = cnt_ap;
		if (fire) begin
			cnt_n = cnt_ap + n_res;
			if (cnt_ap == 2'd0) begin
				buf_n[0] = res[0];
				buf_n[1] = res[1];
			end else if (cnt_ap == 2'd1) begin
				buf_n[1] = res[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		buf_q[0] <= buf_n[0];
		buf_q[1] <= buf_n[1];
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata = TW'({buf_q[0].col, buf_q[0].line, buf_q[0].text});
	assign m_axis_tlast = buf_q[0].last;
	assign m_axis_tuser = {buf_q[0].has, buf_q[0].kind};

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi_s1 |=> mode_q == lft_pkg::M_GROUND && cur_line_q == POS_ONE &&
			cur_col_q == POS_ONE && !hv_q)
		else $error("end of input did not restore the reset state");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == lft_pkg::M_ERROR && !(fire && eoi_s1) |=> mode_q == lft_pkg::M_ERROR)
		else $error("error mode left without end of input");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && buf_q[0].kind == lft_pkg::TK_EOF |-> buf_q[0].last && !buf_q[0].has)
		else $error("end-of-file result malformed");

	a_text_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && buf_q[0].has |->
			buf_q[0].kind == lft_pkg::TK_IDENT || buf_q[0].kind == lft_pkg::TK_STRING)
		else $error("text byte on a token without text");
`endif

endmodule
